// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GNE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gne_pkg.sv -----
package gne_pkg;

  localparam int MAX_SEG = 64;
  localparam int ADDR_W  = $clog2(MAX_SEG + 1);
  localparam int CFG_W   = 7;
  localparam int POS_W   = 24;
  localparam int DIFF_W  = POS_W + 1;
  localparam int NRM_W   = 16;
  localparam int CRS_W   = 2 * DIFF_W + 1;
  localparam int MUL_W   = 31;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NORM_W  = 30;
  localparam int LEN_W   = 32;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = NORM_W + QUO_W + 1;
  localparam int REM_W   = LEN_W + 1;
  localparam logic [NRM_W-1:0] ONE_Q14 = NRM_W'(16384);

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [ADDR_W-1:0]       out_col;
    logic [ADDR_W-1:0]       out_row;
    logic                    degenerate;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t              du;
    vec_t              dv;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] row;
    logic              last;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  typedef enum logic [2:0] {
    F_IDLE, F_RD0, F_RD1, F_RD2, F_J1, F_J2, F_J3, F_FIN
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_ABS, B_NORM, B_SQ, B_SQRT, B_DSET, B_DIV, B_OUT
  } back_state_e;

  function automatic vec_t vsub(in_t a, in_t b);
    vec_t r;
    r.x = {a.pos_x[POS_W-1], a.pos_x} - {b.pos_x[POS_W-1], b.pos_x};
    r.y = {a.pos_y[POS_W-1], a.pos_y} - {b.pos_y[POS_W-1], b.pos_y};
    r.z = {a.pos_z[POS_W-1], a.pos_z} - {b.pos_z[POS_W-1], b.pos_z};
    return r;
  endfunction

endpackage

// ----- rtl/grid_normal_estimator.sv -----
// Surface normals of a square grid streamed in row-major order.
// Input queue side: push_i with in_data_i (Q8.16 position); full_o high means
// the vertex is not taken. Result queue side: empty_o low shows the oldest
// normal on out_data_o (Q1.14, with column, row, degenerate and last flag);
// pop_i takes it. Config: cfg_we_i writes segments (clamped to 1..64) and
// restarts the grid at row 0, column 0.
// Row-0 vertices give no result; later vertices give one to three normals.
// The front takes a vertex and then closes it; a row-0 vertex needs nothing
// more. Later rows first read the row store, then hand each normal to a
// 4-deep request queue, stalling while it is full. The back computes one
// normal at a time: it takes the request, forms the cross product on one
// shared multiplier, takes magnitudes, normalizes them with one-bit shifts,
// squares them, takes the square root of their sum, divides each component
// and writes the result queue; a degenerate normal skips the squares, root
// and division. That back loop sets the throughput.
// Reset clears counters and queues and sets segments to 1. When the receiver
// stops popping, the 2-entry result queue and then the request queue fill,
// and full_o holds the input side; nothing is dropped.
module grid_normal_estimator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  logic          push_i,
  input  gne_pkg::in_t  in_data_i,
  output logic          full_o,
  output logic          empty_o,
  output gne_pkg::out_t out_data_o,
  input  logic          pop_i
);
  import gne_pkg::*;

  job_t front_job, back_job;
  hs_t front_hs;
  logic jq_ready, jq_valid, back_ready;

  gne_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .in_data_i   (in_data_i),
    .full_o      (full_o),
    .job_o       (front_job),
    .job_hs_o    (front_hs),
    .job_ready_i (jq_ready)
  );

  gne_jobq u_jobq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_hs_i    (front_hs),
    .wr_data_i  (front_job),
    .wr_ready_o (jq_ready),
    .rd_valid_o (jq_valid),
    .rd_data_o  (back_job),
    .rd_ready_i (back_ready)
  );

  gne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (jq_valid),
    .job_i       (back_job),
    .job_ready_o (back_ready),
    .empty_o     (empty_o),
    .out_data_o  (out_data_o),
    .pop_i       (pop_i)
  );

endmodule

// ----- rtl/gne_front.sv -----
module gne_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                push_i,
  input  gne_pkg::in_t        in_data_i,
  output logic                full_o,
  output gne_pkg::job_t       job_o,
  output gne_pkg::hs_t        job_hs_o,
  input  logic                job_ready_i
);
  import gne_pkg::*;

  front_state_e state_q, state_d;
  logic [ADDR_W-1:0] seg_q, col_q, row_q, rd_addr;
  logic sel_q, rd_en, accept, last_row, at_end, job_valid;
  in_t p_q, prev_q, uprev_q, ub_q, un_q, rd_q;
  in_t mem0 [MAX_SEG+1];
  in_t mem1 [MAX_SEG+1];

  assign accept   = (state_q == F_IDLE) && push_i;
  assign last_row = (row_q == seg_q);
  assign at_end   = (col_q == seg_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (push_i) state_d = (row_q != '0) ? F_RD0 : F_FIN;
      F_RD0:  state_d = F_RD1;
      F_RD1:  state_d = F_RD2;
      F_RD2:  state_d = F_J1;
      F_J1:   if (job_ready_i) state_d = (last_row && col_q != '0) ? F_J2 : F_FIN;
      F_J2:   if (job_ready_i) state_d = at_end ? F_J3 : F_FIN;
      F_J3:   if (job_ready_i) state_d = F_FIN;
      F_FIN:  state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    job_o     = '0;
    job_valid = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = col_q;
    full_o    = (state_q != F_IDLE);
    unique case (state_q)
      F_RD0: rd_en = 1'b1;
      F_RD1: begin
        rd_en   = 1'b1;
        rd_addr = at_end ? col_q - ADDR_W'(1) : col_q + ADDR_W'(1);
      end
      F_J1: begin
        job_valid = 1'b1;
        job_o.du  = at_end ? vsub(ub_q, un_q) : vsub(un_q, ub_q);
        job_o.dv  = vsub(p_q, ub_q);
        job_o.col = col_q;
        job_o.row = row_q - ADDR_W'(1);
        job_o.last = !(last_row && col_q != '0);
      end
      F_J2: begin
        job_valid = 1'b1;
        job_o.du  = vsub(p_q, prev_q);
        // at the last column the left upper neighbor came from the second read
        job_o.dv  = vsub(prev_q, at_end ? un_q : uprev_q);
        job_o.col = col_q - ADDR_W'(1);
        job_o.row = row_q;
        job_o.last = !at_end;
      end
      F_J3: begin
        job_valid  = 1'b1;
        job_o.du   = vsub(p_q, prev_q);
        job_o.dv   = vsub(p_q, ub_q);
        job_o.col  = col_q;
        job_o.row  = row_q;
        job_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  assign job_hs_o.valid = job_valid;
  assign job_hs_o.ready = job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      seg_q   <= ADDR_W'(1);
      col_q   <= '0;
      row_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) seg_q <= ADDR_W'(1);
        else if (int'(cfg_wdata_i) > MAX_SEG) seg_q <= ADDR_W'(MAX_SEG);
        else seg_q <= ADDR_W'(cfg_wdata_i);
        col_q <= '0;
        row_q <= '0;
      end else if (state_q == F_FIN) begin
        if (at_end) begin
          // swap row banks: the finished row becomes the upper row
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + ADDR_W'(1);
          sel_q <= !sel_q;
        end else begin
          col_q <= col_q + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) p_q <= in_data_i;
    if (state_q == F_RD1) ub_q <= rd_q;
    if (state_q == F_RD2) un_q <= rd_q;
    if (state_q == F_FIN) begin
      prev_q  <= p_q;
      uprev_q <= ub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !sel_q) mem0[col_q] <= in_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept && sel_q) mem1[col_q] <= in_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= sel_q ? mem0[rd_addr] : mem1[rd_addr];
  end

endmodule

// ----- rtl/gne_jobq.sv -----
module gne_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gne_pkg::hs_t  wr_hs_i,
  input  gne_pkg::job_t wr_data_i,
  output logic          wr_ready_o,
  output logic          rd_valid_o,
  output gne_pkg::job_t rd_data_o,
  input  logic          rd_ready_i
);
  import gne_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  job_t buf_q [DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [PTR_W:0] cnt_q;
  logic do_wr, do_rd;

  assign wr_ready_o = (cnt_q != (PTR_W+1)'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = buf_q[rp_q];
  assign do_wr = wr_hs_i.valid && wr_ready_o;
  assign do_rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + PTR_W'(1);
      if (do_rd) rp_q <= rp_q + PTR_W'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + (PTR_W+1)'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) buf_q[wp_q] <= wr_data_i;
  end

endmodule

// ----- rtl/gne_back.sv -----
module gne_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  gne_pkg::job_t job_i,
  output logic          job_ready_o,
  output logic          empty_o,
  output gne_pkg::out_t out_data_o,
  input  logic          pop_i
);
  import gne_pkg::*;

  back_state_e state_q, state_d;
  job_t job_q;
  logic [3:0] k_q;
  logic [1:0] j_q;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [CRS_W-1:0] crs_q [3];
  logic [CRS_W-1:0] mag_q [3];
  logic [CRS_W-1:0] mx;
  logic [2:0] neg_q;
  logic degen_q;
  logic [PROD_W-1:0] l2_q, v_q, res_q, bit_q, sq_t, res_nx;
  logic [LEN_W-1:0] len_q;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] rem_q, dvs;
  logic [REM_W:0] rem2;
  logic [QUO_W-1:0] nlo_q, quo_q, quo_nx;
  logic [NRM_W-1:0] qmag;
  logic signed [NRM_W-1:0] nrm_q [3];
  logic mul_done, sq_done, div_done;
  out_t oq_q [2];
  logic oq_wp_q, oq_rp_q, oq_full, oq_wr, oq_rd;
  logic [1:0] oq_cnt_q;

  function automatic logic signed [MUL_W-1:0] sx(logic signed [DIFF_W-1:0] v);
    return {{(MUL_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  assign mul_done = (k_q == 4'd6);
  assign sq_done  = (k_q == 4'd3);
  assign div_done = (k_q == 4'(QUO_W - 1));
  assign oq_full  = (oq_cnt_q == 2'd2);

  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
  end

  // shared multiplier: cross terms first, then squares of the scaled magnitudes
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == B_MUL) begin
      case (k_q)
        4'd0: begin mul_a = sx(job_q.dv.y); mul_b = sx(job_q.du.z); end
        4'd1: begin mul_a = sx(job_q.dv.z); mul_b = sx(job_q.du.y); end
        4'd2: begin mul_a = sx(job_q.dv.z); mul_b = sx(job_q.du.x); end
        4'd3: begin mul_a = sx(job_q.dv.x); mul_b = sx(job_q.du.z); end
        4'd4: begin mul_a = sx(job_q.dv.x); mul_b = sx(job_q.du.y); end
        4'd5: begin mul_a = sx(job_q.dv.y); mul_b = sx(job_q.du.x); end
        default: ;
      endcase
    end else if (state_q == B_SQ) begin
      case (k_q)
        4'd0: mul_a = {1'b0, mag_q[0][NORM_W-1:0]};
        4'd1: mul_a = {1'b0, mag_q[1][NORM_W-1:0]};
        4'd2: mul_a = {1'b0, mag_q[2][NORM_W-1:0]};
        default: ;
      endcase
      mul_b = mul_a;
    end
  end

  always_comb begin
    sq_t   = res_q + bit_q;
    res_nx = (v_q >= sq_t) ? (res_q >> 1) + bit_q : res_q >> 1;
    num    = NUM_W'({mag_q[j_q][NORM_W-1:0], {QUO_W{1'b0}}}) + NUM_W'(len_q);
    dvs    = {len_q, 1'b0};
    rem2   = {rem_q, nlo_q[QUO_W-1]};
    quo_nx = {quo_q[QUO_W-2:0], (rem2 >= {1'b0, dvs})};
    qmag   = ({1'b0, quo_nx} > ONE_Q14) ? ONE_Q14 : {1'b0, quo_nx};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (job_valid_i) state_d = B_MUL;
      B_MUL:  if (mul_done) state_d = B_ABS;
      B_ABS:  state_d = B_NORM;
      B_NORM: begin
        if (degen_q) state_d = B_OUT;
        else if (mx < CRS_W'(1 << 30) && mx >= CRS_W'(1 << 29)) state_d = B_SQ;
      end
      B_SQ:   if (sq_done) state_d = B_SQRT;
      B_SQRT: if (bit_q[0]) state_d = B_DSET;
      B_DSET: state_d = B_DIV;
      B_DIV:  if (div_done) state_d = (j_q == 2'd2) ? B_OUT : B_DSET;
      B_OUT:  if (!oq_full) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == B_IDLE);
    oq_wr       = (state_q == B_OUT) && !oq_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      B_IDLE: begin
        job_q <= job_i;
        k_q   <= '0;
      end
      B_MUL: begin
        k_q <= mul_done ? 4'd0 : k_q + 4'd1;
        case (k_q)
          4'd1: crs_q[0] <= prod_q[CRS_W-1:0];
          4'd2: crs_q[0] <= crs_q[0] - prod_q[CRS_W-1:0];
          4'd3: crs_q[1] <= prod_q[CRS_W-1:0];
          4'd4: crs_q[1] <= crs_q[1] - prod_q[CRS_W-1:0];
          4'd5: crs_q[2] <= prod_q[CRS_W-1:0];
          4'd6: crs_q[2] <= crs_q[2] - prod_q[CRS_W-1:0];
          default: ;
        endcase
      end
      B_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= crs_q[i][CRS_W-1];
          mag_q[i] <= crs_q[i][CRS_W-1] ? CRS_W'(-crs_q[i]) : CRS_W'(crs_q[i]);
          nrm_q[i] <= '0;
        end
        degen_q <= (crs_q[0] == '0) && (crs_q[1] == '0) && (crs_q[2] == '0);
      end
      B_NORM: begin
        // move the largest magnitude into [2^29, 2^30) one bit a cycle
        if (mx >= CRS_W'(1 << 30)) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (mx < CRS_W'(1 << 29)) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
        k_q  <= '0;
        l2_q <= '0;
      end
      B_SQ: begin
        k_q <= k_q + 4'd1;
        if (k_q != '0) l2_q <= l2_q + PROD_W'(prod_q);
        if (sq_done) begin
          v_q   <= l2_q + PROD_W'(prod_q);
          res_q <= '0;
          bit_q <= PROD_W'(1) << 60;
        end
      end
      B_SQRT: begin
        if (v_q >= sq_t) v_q <= v_q - sq_t;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          len_q <= res_nx[LEN_W-1:0];
          j_q   <= '0;
        end
      end
      B_DSET: begin
        rem_q <= REM_W'(num[NUM_W-1:QUO_W]);
        nlo_q <= num[QUO_W-1:0];
        quo_q <= '0;
        k_q   <= '0;
      end
      B_DIV: begin
        rem_q <= quo_nx[0] ? REM_W'(rem2 - {1'b0, dvs}) : rem2[REM_W-1:0];
        nlo_q <= nlo_q << 1;
        quo_q <= quo_nx;
        k_q   <= k_q + 4'd1;
        if (div_done) begin
          nrm_q[j_q] <= neg_q[j_q] ? NRM_W'(-qmag) : qmag;
          j_q <= j_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // result queue
  assign empty_o    = (oq_cnt_q == '0);
  assign out_data_o = oq_q[oq_rp_q];
  assign oq_rd      = !empty_o && pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_wr) oq_wp_q <= !oq_wp_q;
      if (oq_rd) oq_rp_q <= !oq_rp_q;
      if (oq_wr && !oq_rd) oq_cnt_q <= oq_cnt_q + 2'd1;
      else if (oq_rd && !oq_wr) oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_q[oq_wp_q].normal_x   <= nrm_q[0];
      oq_q[oq_wp_q].normal_y   <= nrm_q[1];
      oq_q[oq_wp_q].normal_z   <= nrm_q[2];
      oq_q[oq_wp_q].out_col    <= job_q.col;
      oq_q[oq_wp_q].out_row    <= job_q.row;
      oq_q[oq_wp_q].degenerate <= degen_q;
      oq_q[oq_wp_q].last       <= job_q.last;
    end
  end

endmodule

// ----- rtl/gne_checker.sv -----
`include "assert_macros.svh"

module gne_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cfg_we_i,
  input logic [6:0]    cfg_wdata_i,
  input logic          push_i,
  input gne_pkg::in_t  in_data_i,
  input logic          full_o,
  input logic          empty_o,
  input gne_pkg::out_t out_data_o,
  input logic          pop_i
);
  import gne_pkg::*;

  // one vertex at a time: the front goes busy right after taking a request
  `GNE_ASSERT_NEXT(a_busy_after_push, clk_i, rst_ni, push_i && !full_o, full_o, "full_o low after push")
  `GNE_ASSERT_NEXT(a_hold_result, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(out_data_o), "result changed while stalled")
  `GNE_ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, !empty_o && out_data_o.degenerate, out_data_o.normal_x == 0 && out_data_o.normal_y == 0 && out_data_o.normal_z == 0, "degenerate normal not zero")
  `GNE_ASSERT_IMPL(a_unit_range, clk_i, rst_ni, !empty_o, out_data_o.normal_x <= 16384 && out_data_o.normal_x >= -16384 && out_data_o.normal_y <= 16384 && out_data_o.normal_y >= -16384 && out_data_o.normal_z <= 16384 && out_data_o.normal_z >= -16384, "normal component out of range")
  `GNE_ASSERT_IMPL(a_pos_range, clk_i, rst_ni, !empty_o, int'(out_data_o.out_col) <= MAX_SEG && int'(out_data_o.out_row) <= MAX_SEG, "grid position out of range")

endmodule

bind grid_normal_estimator gne_checker u_chk (.*);
